// File: rtl/sct_pkg.sv
// ----------------------------------------------------------------------------
// Serial command thermostat package
// Shared transfer types, mode codes, register indexes and character codes.
// ----------------------------------------------------------------------------
package sct_pkg;

   localparam int SAMPLE_W = 10;
   localparam int LEVEL_W  = 10;
   localparam int CSR_ADDR_W = 1;
   localparam int KEEP_CHARS = 3;

   localparam logic [1:0] MODE_BYTE   = 2'd0;
   localparam logic [1:0] MODE_SAMPLE = 2'd1;
   localparam logic [1:0] MODE_BUTTON = 2'd2;

   localparam logic [CSR_ADDR_W-1:0] CSR_FAN_ON_LEVEL  = 1'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_FAN_OFF_LEVEL = 1'd1;

   localparam logic [LEVEL_W-1:0] FAN_ON_LEVEL_RST  = 10'd81;
   localparam logic [LEVEL_W-1:0] FAN_OFF_LEVEL_RST = 10'd60;

   localparam logic [7:0] CHAR_CR  = 8'h0D;
   localparam logic [7:0] CHAR_L   = 8'h4C;
   localparam logic [7:0] CHAR_G   = 8'h47;
   localparam logic [7:0] CHAR_D   = 8'h44;
   localparam logic [7:0] CHAR_A   = 8'h41;
   localparam logic [7:0] CHAR_ONE = 8'h31;
   localparam logic [7:0] CHAR_FOUR = 8'h34;

   typedef struct packed {
      logic [1:0]          mode;
      logic [7:0]          rx_byte;
      logic [SAMPLE_W-1:0] temp_sample;
   } req_type;

   typedef struct packed {
      logic [3:0] led_bits;
      logic       heater_on;
      logic       fan_on;
      logic       line_ended;
      logic       command_hit;
   } rsp_type;

endpackage

// File: rtl/serial_command_thermostat_core.sv
// ----------------------------------------------------------------------------
// Serial command thermostat core
// Collects serial command lines, evaluates LED and heater commands on carriage
// return, and drives heater and fan from temperature samples and a button.
// ----------------------------------------------------------------------------
// An accepted input transfer has its result in the output register from the next clock.
// Throughput: one item per cycle if not stalled; the state update is a single compare stage.
// The output register frees itself in the cycle its result is taken.
// Reset: line buffer, LEDs, heater and fan clear; levels return to 81 and 60.

module serial_command_thermostat_core #(
   parameter int LINE_DEPTH = 5
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  sct_pkg::req_type                  req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output sct_pkg::rsp_type                  rsp_data,
   input  logic                              csr_we,
   input  logic [sct_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  logic [sct_pkg::LEVEL_W-1:0]       csr_wdata
);

   localparam int CNT_W = $clog2(LINE_DEPTH + 1);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(LINE_DEPTH);

   logic [sct_pkg::LEVEL_W-1:0] fan_on_level_ff, fan_off_level_ff;
   logic [7:0]        line_ff [sct_pkg::KEEP_CHARS];
   logic [7:0]        line_in [sct_pkg::KEEP_CHARS];
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [3:0]        led_ff, led_in;
   logic              heater_ff, heater_in;
   logic              fan_ff, fan_in;
   logic              rsp_valid_ff, rsp_valid_in;
   sct_pkg::rsp_type  rsp_ff, rsp_in;

   logic              req_fire;
   logic              is_cr, hit, ended;
   logic              prefix_lg, prefix_dg, digit_ok;
   logic [7:0]        digit_off;
   logic [3:0]        led_mask;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign is_cr     = req_data.rx_byte == sct_pkg::CHAR_CR;
   assign prefix_lg = line_ff[0] == sct_pkg::CHAR_L && line_ff[1] == sct_pkg::CHAR_G;
   assign prefix_dg = line_ff[0] == sct_pkg::CHAR_D && line_ff[1] == sct_pkg::CHAR_G;
   assign digit_ok  = line_ff[2] >= sct_pkg::CHAR_ONE && line_ff[2] <= sct_pkg::CHAR_FOUR;
   assign digit_off = line_ff[2] - sct_pkg::CHAR_ONE;
   assign led_mask  = 4'b0001 << digit_off[1:0];

   always_comb begin
      line_in   = line_ff;
      count_in  = count_ff;
      led_in    = led_ff;
      heater_in = heater_ff;
      fan_in    = fan_ff;
      hit       = 1'b0;
      ended     = 1'b0;
      case (req_data.mode)
         sct_pkg::MODE_BYTE: begin
            if (is_cr) begin
               ended = 1'b1;
               if (prefix_lg && digit_ok) begin
                  led_in = led_ff | led_mask;
                  hit    = 1'b1;
               end else if (prefix_lg && line_ff[2] == sct_pkg::CHAR_A) begin
                  heater_in = 1'b1;
                  hit       = 1'b1;
               end else if (prefix_dg && digit_ok) begin
                  led_in = led_ff & ~led_mask;
                  hit    = 1'b1;
               end
               for (int i = 0; i < sct_pkg::KEEP_CHARS; i++) begin
                  line_in[i] = 8'd0;
               end
               count_in = '0;
            end else if (count_ff < CNT_MAX) begin
               for (int i = 0; i < sct_pkg::KEEP_CHARS; i++) begin
                  if (count_ff == CNT_W'(i)) begin
                     line_in[i] = req_data.rx_byte;
                  end
               end
               count_in = count_ff + CNT_W'(1);
            end
         end
         sct_pkg::MODE_SAMPLE: begin
            if (req_data.temp_sample >= fan_on_level_ff) begin
               heater_in = 1'b0;
               fan_in    = 1'b1;
            end
            if (req_data.temp_sample <= fan_off_level_ff) begin
               fan_in = 1'b0;
            end
         end
         sct_pkg::MODE_BUTTON: begin
            heater_in = 1'b1;
         end
         default: begin
         end
      endcase
      rsp_in.led_bits    = led_in;
      rsp_in.heater_on   = heater_in;
      rsp_in.fan_on      = fan_in;
      rsp_in.line_ended  = ended;
      rsp_in.command_hit = hit;
      rsp_valid_in       = req_fire || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fan_on_level_ff  <= sct_pkg::FAN_ON_LEVEL_RST;
         fan_off_level_ff <= sct_pkg::FAN_OFF_LEVEL_RST;
      end else if (csr_we) begin
         unique case (csr_addr)
            sct_pkg::CSR_FAN_ON_LEVEL:  fan_on_level_ff  <= csr_wdata;
            sct_pkg::CSR_FAN_OFF_LEVEL: fan_off_level_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < sct_pkg::KEEP_CHARS; i++) begin
            line_ff[i] <= 8'd0;
         end
         count_ff     <= '0;
         led_ff       <= 4'd0;
         heater_ff    <= 1'b0;
         fan_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_fire) begin
            line_ff   <= line_in;
            count_ff  <= count_in;
            led_ff    <= led_in;
            heater_ff <= heater_in;
            fan_ff    <= fan_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_ff <= rsp_in;
      end
   end

   a_hit_needs_line_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.line_ended || !rsp_data.command_hit))
      else $error("command hit reported without a line end");

   a_hot_sample: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_data.mode == sct_pkg::MODE_SAMPLE
       && req_data.temp_sample >= fan_on_level_ff
       && req_data.temp_sample > fan_off_level_ff)
      |=> (rsp_valid && rsp_data.fan_on && !rsp_data.heater_on))
      else $error("hot sample did not start the fan and stop the heater");

   a_button_heater: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_data.mode == sct_pkg::MODE_BUTTON) |=> rsp_data.heater_on)
      else $error("button press did not turn the heater on");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_MAX)
      else $error("line count past its depth");

endmodule
